[rtl/core/nearest_bone_select_top_assert.svh]
// Assertion macros shared by the RTL; clk and rst_n must be in scope.
`ifndef NEAREST_BONE_SELECT_TOP_ASSERT_SVH
`define NEAREST_BONE_SELECT_TOP_ASSERT_SVH

// expr must never hold outside reset
`define NBS_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

// cond implies prop in the same cycle
`define NBS_ASSERT_IMPLIES(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

[rtl/core/nbs_pkg.sv]
package nbs_pkg;

    localparam int IDX_W     = 5;
    localparam int CFG_W     = 6;
    localparam int OUT_SUM_W = 18;

    localparam logic [OUT_SUM_W-1:0] SUM_MAX = 18'h3FFFF;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

[rtl/core/nbs_if.sv]
interface nbs_item_if #(parameter int COORD_WIDTH = 16);
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [nbs_pkg::IDX_W-1:0]     bone_slot;
    logic signed [COORD_WIDTH-1:0] end_a_x;
    logic signed [COORD_WIDTH-1:0] end_a_y;
    logic signed [COORD_WIDTH-1:0] end_a_z;
    logic signed [COORD_WIDTH-1:0] end_b_x;
    logic signed [COORD_WIDTH-1:0] end_b_y;
    logic signed [COORD_WIDTH-1:0] end_b_z;
    logic signed [COORD_WIDTH-1:0] vertex_x;
    logic signed [COORD_WIDTH-1:0] vertex_y;
    logic signed [COORD_WIDTH-1:0] vertex_z;

    modport source (
        output valid, mode, bone_slot, end_a_x, end_a_y, end_a_z,
               end_b_x, end_b_y, end_b_z, vertex_x, vertex_y, vertex_z,
        input  ready
    );
    modport sink (
        input  valid, mode, bone_slot, end_a_x, end_a_y, end_a_z,
               end_b_x, end_b_y, end_b_z, vertex_x, vertex_y, vertex_z,
        output ready
    );
endinterface

interface nbs_result_if;
    logic                          valid;
    logic                          ready;
    logic [nbs_pkg::IDX_W-1:0]     nearest_index;
    logic [nbs_pkg::OUT_SUM_W-1:0] distance_sum;
    logic                          found;

    modport source (output valid, nearest_index, distance_sum, found, input ready);
    modport sink (input valid, nearest_index, distance_sum, found, output ready);
endinterface

interface nbs_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [nbs_pkg::CFG_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/core/nearest_bone_select_top.sv]
// Channel  Dir  Payload
// item     in   mode, bone_slot, end_a_xyz, end_b_xyz, vertex_xyz
// result   out  nearest_index, distance_sum, found
// cfg      in   data (bones_in_use)
//
// A load writes the slot into the bone memory.
// A query over n bones makes one memory read per slot, then waits for
// the fill of the square-root pipeline (COORD_WIDTH + 1 stages).
// A query with no bones in use goes straight to the result without a scan.
// rst_n clears control state and bones_in_use; bone memory contents are kept.
// The result register lets the next item be accepted while a result is stalled.
`include "nearest_bone_select_top_assert.svh"

module nearest_bone_select_top #(
    parameter int NUM_BONES   = 32,
    parameter int COORD_WIDTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    nbs_item_if.sink     item,
    nbs_result_if.source result,
    nbs_cfg_if.sink      cfg
);

    localparam int AW   = (NUM_BONES > 1) ? $clog2(NUM_BONES) : 1;
    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int MW   = 6 * CW;
    localparam int RW   = 2 * CW + 2;
    localparam int RT   = RW / 2;
    localparam int SW   = CW + 2;
    localparam int TW   = AW + 1;
    localparam int CNTW = $clog2(NUM_BONES + 1);
    localparam int XW   = (CNTW > nbs_pkg::CFG_W) ? CNTW : nbs_pkg::CFG_W;
    localparam int XSW  = (SW > nbs_pkg::OUT_SUM_W) ? SW : nbs_pkg::OUT_SUM_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

    state_t                   state_reg;
    logic [nbs_pkg::CFG_W-1:0] bones_in_use_reg;
    logic [AW-1:0]            scan_idx_reg;
    logic [AW-1:0]            last_idx_reg;
    logic [SW-1:0]            best_reg;
    logic [AW-1:0]            best_idx_reg;
    logic                     found_reg;
    logic                     res_valid_reg;
    logic [nbs_pkg::IDX_W-1:0]     res_idx_reg;
    logic [nbs_pkg::OUT_SUM_W-1:0] res_sum_reg;
    logic                     res_found_reg;

    logic signed [CW-1:0]     vert_reg [3];
    logic                     p1_valid_reg;
    logic [TW-1:0]            p1_tag_reg;
    logic                     p2_valid_reg;
    logic [TW-1:0]            p2_tag_reg;
    logic [2*CW:0]            sq_reg [6];

    logic                     item_xfer;
    logic                     issue;
    logic [XW-1:0]            cfg_x;
    logic [XW-1:0]            n_x;
    logic [8:0]               slot9;
    logic                     mem_wr_en;
    logic [MW-1:0]            mem_rd_data;
    logic signed [DW-1:0]     diff_w [6];
    logic signed [2*DW-1:0]   prod_w [6];
    logic [RW-1:0]            rad_w [2];
    logic                     sq_out_valid;
    logic [TW-1:0]            sq_out_tag;
    logic [RT-1:0]            root_w [2];
    logic [SW-1:0]            sum_w;
    logic [XSW-1:0]           best_x;
    logic [8:0]               best_idx9;

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign item_xfer  = item.valid && item.ready;
    assign issue      = (state_reg == ST_SCAN);

    assign cfg_x = XW'(bones_in_use_reg);
    assign n_x   = (cfg_x > XW'(NUM_BONES)) ? XW'(NUM_BONES) : cfg_x;

    assign slot9     = 9'(item.bone_slot);
    assign mem_wr_en = item_xfer && (item.mode == nbs_pkg::MODE_LOAD)
                       && (slot9 < 9'(NUM_BONES));

    nbs_bone_mem #(
        .DEPTH (NUM_BONES),
        .WIDTH (MW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (slot9[AW-1:0]),
        .wr_data ({item.end_a_x, item.end_a_y, item.end_a_z,
                   item.end_b_x, item.end_b_y, item.end_b_z}),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg),
        .rd_data (mem_rd_data)
    );

    // lanes 0..2 are endpoint A, 3..5 endpoint B
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            diff_w[k] = $signed({mem_rd_data[(5-k)*CW + CW - 1], mem_rd_data[(5-k)*CW +: CW]})
                        - $signed({vert_reg[k%3][CW-1], vert_reg[k%3]});
            prod_w[k] = diff_w[k] * diff_w[k];
        end
        rad_w[0] = RW'(sq_reg[0]) + RW'(sq_reg[1]) + RW'(sq_reg[2]);
        rad_w[1] = RW'(sq_reg[3]) + RW'(sq_reg[4]) + RW'(sq_reg[5]);
    end

    always_ff @(posedge clk)
    begin
        if (item_xfer && (item.mode == nbs_pkg::MODE_QUERY))
        begin
            vert_reg[0] <= item.vertex_x;
            vert_reg[1] <= item.vertex_y;
            vert_reg[2] <= item.vertex_z;
        end
        p1_tag_reg <= {scan_idx_reg == last_idx_reg, scan_idx_reg};
        p2_tag_reg <= p1_tag_reg;
        for (int k = 0; k < 6; k++)
        begin
            sq_reg[k] <= prod_w[k][2*CW:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    nbs_isqrt #(
        .RW (RW),
        .TW (TW)
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .in_tag    (p2_tag_reg),
        .in_rad    (rad_w),
        .out_valid (sq_out_valid),
        .out_tag   (sq_out_tag),
        .out_root  (root_w)
    );

    assign sum_w     = SW'(root_w[0]) + SW'(root_w[1]);
    assign best_x    = XSW'(best_reg);
    assign best_idx9 = 9'(best_idx_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            bones_in_use_reg <= '0;
            scan_idx_reg     <= '0;
            last_idx_reg     <= '0;
            best_reg         <= '0;
            best_idx_reg     <= '0;
            found_reg        <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_idx_reg      <= '0;
            res_sum_reg      <= '0;
            res_found_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                bones_in_use_reg <= cfg.data;
            end
            // in ST_DONE the result register is reloaded below
            if (result.valid && result.ready && (state_reg != ST_DONE))
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (item_xfer && (item.mode == nbs_pkg::MODE_QUERY))
                    begin
                        found_reg    <= 1'b0;
                        best_reg     <= '0;
                        best_idx_reg <= '0;
                        scan_idx_reg <= '0;
                        last_idx_reg <= AW'(n_x - XW'(1));
                        state_reg    <= (n_x == '0) ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    scan_idx_reg <= scan_idx_reg + AW'(1);
                    if (scan_idx_reg == last_idx_reg)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (sq_out_valid && sq_out_tag[AW])
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!res_valid_reg || result.ready)
                    begin
                        res_valid_reg <= 1'b1;
                        res_found_reg <= found_reg;
                        res_idx_reg   <= best_idx9[nbs_pkg::IDX_W-1:0];
                        res_sum_reg   <= (best_x > XSW'(nbs_pkg::SUM_MAX))
                                         ? nbs_pkg::SUM_MAX
                                         : best_x[nbs_pkg::OUT_SUM_W-1:0];
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // strict less-than keeps the lowest slot on a tie
            if (sq_out_valid && (!found_reg || (sum_w < best_reg)))
            begin
                found_reg    <= 1'b1;
                best_reg     <= sum_w;
                best_idx_reg <= sq_out_tag[AW-1:0];
            end
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.nearest_index = res_idx_reg;
    assign result.distance_sum  = res_sum_reg;
    assign result.found         = res_found_reg;

    `NBS_ASSERT_NEVER(a_sqrt_out_idle, sq_out_valid && ((state_reg == ST_IDLE) || (state_reg == ST_DONE)), "root result outside a query")
    `NBS_ASSERT_NEVER(a_wr_during_scan, mem_wr_en && (state_reg != ST_IDLE), "bone write during query")
    `NBS_ASSERT_NEVER(a_empty_result, result.valid && !result.found && ((result.distance_sum != '0) || (result.nearest_index != '0)), "empty result carries data")
    `NBS_ASSERT_NEVER(a_scan_bound, (state_reg == ST_SCAN) && (scan_idx_reg > last_idx_reg), "scan past last slot")

endmodule

[rtl/core/nbs_bone_mem.sv]
module nbs_bone_mem #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 96
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/nbs_isqrt.sv]
// Two-lane pipelined floor square root, one result bit per stage.
module nbs_isqrt #(
    parameter int RW = 34,
    parameter int TW = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [TW-1:0]     in_tag,
    input  logic [RW-1:0]     in_rad [2],
    output logic              out_valid,
    output logic [TW-1:0]     out_tag,
    output logic [RW/2-1:0]   out_root [2]
);

    localparam int RT = RW / 2;

    logic              valid_reg [RT+1];
    logic [TW-1:0]     tag_reg   [RT+1];
    logic [RW-1:0]     rad_reg   [RT+1][2];
    logic [RT:0]       rem_reg   [RT+1][2];
    logic [RT-1:0]     root_reg  [RT+1][2];

    logic [RT+2:0]     rem2_w    [RT][2];
    logic [RT+2:0]     trial_w   [RT][2];
    logic              ge_w      [RT][2];
    logic [RT+2:0]     diff_w    [RT][2];
    logic [RT:0]       rem_next  [RT][2];
    logic [RT-1:0]     root_next [RT][2];
    logic [RW-1:0]     rad_next  [RT][2];

    always_comb
    begin
        for (int s = 0; s < RT; s++)
        begin
            for (int l = 0; l < 2; l++)
            begin
                rem2_w[s][l]    = {rem_reg[s][l], rad_reg[s][l][RW-1 -: 2]};
                trial_w[s][l]   = (RT+3)'({root_reg[s][l], 2'b01});
                ge_w[s][l]      = rem2_w[s][l] >= trial_w[s][l];
                diff_w[s][l]    = rem2_w[s][l] - trial_w[s][l];
                rem_next[s][l]  = ge_w[s][l] ? diff_w[s][l][RT:0] : rem2_w[s][l][RT:0];
                root_next[s][l] = {root_reg[s][l][RT-2:0], ge_w[s][l]};
                rad_next[s][l]  = rad_reg[s][l] << 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= RT; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int s = 0; s < RT; s++)
            begin
                valid_reg[s+1] <= valid_reg[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int l = 0; l < 2; l++)
        begin
            rad_reg[0][l]  <= in_rad[l];
            rem_reg[0][l]  <= '0;
            root_reg[0][l] <= '0;
        end
        for (int s = 0; s < RT; s++)
        begin
            tag_reg[s+1] <= tag_reg[s];
            for (int l = 0; l < 2; l++)
            begin
                rad_reg[s+1][l]  <= rad_next[s][l];
                rem_reg[s+1][l]  <= rem_next[s][l];
                root_reg[s+1][l] <= root_next[s][l];
            end
        end
    end

    assign out_valid   = valid_reg[RT];
    assign out_tag     = tag_reg[RT];
    assign out_root[0] = root_reg[RT][0];
    assign out_root[1] = root_reg[RT][1];

endmodule
